FILE: rtl/core/smr_pkg.sv
package smr_pkg;

   // One input item: a signed Q8.8 score and the end-of-row flag.
   typedef struct packed {
      logic signed [15:0] score;
      logic               last_in_row;
   } req_item_type;

   // One result item: an unsigned Q1.16 probability and its flags.
   typedef struct packed {
      logic [16:0] prob;
      logic        last_out;
      logic        truncated;
   } rsp_item_type;

   // Sequencer states of the back end.
   typedef enum logic [2:0] {
      BK_IDLE,
      BK_EXP_RD,
      BK_EXP_MUL,
      BK_EXP_ACC,
      BK_DIV_RD,
      BK_DIV_LOAD,
      BK_DIV_RUN,
      BK_DIV_OUT
   } back_state_type;

   localparam int SCORE_W     = 16;
   localparam int EXP_W       = 17;
   localparam int LOG2E_Q8    = 369;
   localparam int SHIFT_LIMIT = 17;
   localparam int FRAC_STEPS  = 16;

   typedef logic [255:0][EXP_W-1:0] exp_table_type;

   // T[f] = round(65536 * 2^(-f/256)), evaluated at elaboration only.
   function automatic exp_table_type build_exp_table();
      exp_table_type t;
      real           v;
      for (int f = 0; f < 256; f++) begin
         v = 65536.0 * $pow(2.0, -real'(f) / 256.0);
         t[f] = EXP_W'($rtoi(v + 0.5));
      end
      return t;
   endfunction

   localparam exp_table_type EXP_TABLE = build_exp_table();

endpackage

FILE: rtl/core/smr_ram.sv
module smr_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // One write port and one registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: rtl/core/smr_queue.sv
module smr_queue #(
   parameter int DATA_W = 8
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  logic [DATA_W-1:0] push_data,
   input  logic              pop,
   output logic              head_valid,
   output logic [DATA_W-1:0] head_data
);

   logic [DATA_W-1:0] entry_ff [2];
   logic              wr_ptr_ff, wr_ptr_in;
   logic              rd_ptr_ff, rd_ptr_in;
   logic [1:0]        fill_ff, fill_in;

   // Pointer and fill bookkeeping for the two-entry queue of closed rows.
   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? ~rd_ptr_ff : rd_ptr_ff;
      fill_in   = fill_ff + 2'(push) - 2'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         fill_ff   <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

   assign head_valid = (fill_ff != 2'd0);
   assign head_data  = entry_ff[rd_ptr_ff];

endmodule

FILE: rtl/core/smr_front.sv
module smr_front #(
   parameter int MAX_COLS = 64,
   parameter int IDX_W    = 6,
   parameter int CNT_W    = 7,
   parameter int JOB_W    = 25
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_stall,
   input  smr_pkg::req_item_type      req_data,
   output logic                       score_wr_en,
   output logic [IDX_W:0]             score_wr_addr,
   output logic [smr_pkg::SCORE_W-1:0] score_wr_data,
   output logic                       job_push,
   output logic [JOB_W-1:0]           job_data,
   input  logic                       row_done
);

   typedef struct packed {
      logic                              bank;
      logic [CNT_W-1:0]                  count;
      logic signed [smr_pkg::SCORE_W-1:0] row_max;
      logic                              overflow;
   } job_type;

   logic [CNT_W-1:0]                  count_ff, count_in;
   logic signed [smr_pkg::SCORE_W-1:0] max_ff, max_in;
   logic                              ovf_ff, ovf_in;
   logic                              bank_ff, bank_in;
   logic [1:0]                        open_ff, open_in;
   logic                              accept;
   logic                              has_room;
   job_type                           job;

   // A row fills one bank; both banks busy means no item is taken.
   assign req_stall = (open_ff == 2'd2);
   assign accept    = req_valid && !req_stall;
   assign has_room  = (count_ff < CNT_W'(MAX_COLS));

   assign score_wr_en   = accept && has_room;
   assign score_wr_addr = {bank_ff, count_ff[IDX_W-1:0]};
   assign score_wr_data = req_data.score;

   // Row bookkeeping: count, running maximum and the overflow flag.
   always_comb begin
      count_in = count_ff;
      max_in   = max_ff;
      ovf_in   = ovf_ff;
      if (accept) begin
         if (has_room) begin
            count_in = count_ff + CNT_W'(1);
            if (req_data.score > max_ff) begin
               max_in = req_data.score;
            end
         end else begin
            ovf_in = 1'b1;
         end
      end
      job.bank     = bank_ff;
      job.count    = count_in;
      job.row_max  = max_in;
      job.overflow = ovf_in;
      job_push     = accept && req_data.last_in_row;
      bank_in      = bank_ff;
      if (job_push) begin
         count_in = '0;
         max_in   = -16'sd32768;
         ovf_in   = 1'b0;
         bank_in  = ~bank_ff;
      end
      open_in = open_ff + 2'(job_push) - 2'(row_done);
   end

   assign job_data = job;

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         max_ff   <= -16'sd32768;
         ovf_ff   <= 1'b0;
         bank_ff  <= 1'b0;
         open_ff  <= 2'd0;
      end else begin
         count_ff <= count_in;
         max_ff   <= max_in;
         ovf_ff   <= ovf_in;
         bank_ff  <= bank_in;
         open_ff  <= open_in;
      end
   end

endmodule

FILE: rtl/core/smr_back.sv
module smr_back #(
   parameter int IDX_W = 6,
   parameter int CNT_W = 7,
   parameter int SUM_W = 23,
   parameter int JOB_W = 25
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        job_valid,
   input  logic [JOB_W-1:0]            job_data,
   output logic                        job_pop,
   output logic [IDX_W:0]              score_rd_addr,
   input  logic [smr_pkg::SCORE_W-1:0] score_rd_data,
   output logic                        exp_wr_en,
   output logic [IDX_W-1:0]            exp_wr_addr,
   output logic [smr_pkg::EXP_W-1:0]   exp_wr_data,
   output logic [IDX_W-1:0]            exp_rd_addr,
   input  logic [smr_pkg::EXP_W-1:0]   exp_rd_data,
   output logic                        row_done,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output smr_pkg::rsp_item_type       rsp_data
);

   typedef struct packed {
      logic                              bank;
      logic [CNT_W-1:0]                  count;
      logic signed [smr_pkg::SCORE_W-1:0] row_max;
      logic                              overflow;
   } job_type;

   smr_pkg::back_state_type         state_ff, state_in;
   job_type                         job_ff, job_in;
   logic [IDX_W-1:0]                idx_ff, idx_in;
   logic [16:0]                     y_ff, y_in;
   logic [SUM_W-1:0]                sum_ff, sum_in;
   logic [SUM_W-1:0]                rem_ff, rem_in;
   logic [16:0]                     quo_ff, quo_in;
   logic [3:0]                      step_ff, step_in;
   logic                            rsp_valid_ff, rsp_valid_in;
   smr_pkg::rsp_item_type           rsp_ff, rsp_in;
   logic [smr_pkg::SCORE_W-1:0]     diff;
   logic [24:0]                     prod;
   logic [8:0]                      shift;
   logic [smr_pkg::EXP_W-1:0]       exp_val;
   logic [SUM_W-1:0]                exp_ext;
   logic [SUM_W:0]                  trial;
   logic                            trial_ge;
   logic                            idx_last;
   logic                            out_free;

   // Exponent datapath: d*log2(e) in Q.8, then table lookup and shift.
   assign diff    = job_ff.row_max - score_rd_data;
   assign prod    = {9'd0, diff} * 25'(smr_pkg::LOG2E_Q8);
   assign shift   = y_ff[16:8];
   assign exp_val = (shift >= 9'(smr_pkg::SHIFT_LIMIT)) ? '0 :
                    (smr_pkg::EXP_TABLE[y_ff[7:0]] >> shift[4:0]);

   // Divider datapath: one quotient bit per cycle.
   assign exp_ext  = SUM_W'(exp_rd_data);
   assign trial    = {rem_ff, 1'b0};
   assign trial_ge = (trial >= {1'b0, sum_ff});

   assign idx_last = ((CNT_W'(idx_ff) + CNT_W'(1)) == job_ff.count);
   assign out_free = !rsp_valid_ff || !rsp_stall;

   assign score_rd_addr = {job_ff.bank, idx_ff};
   assign exp_wr_addr   = idx_ff;
   assign exp_wr_data   = exp_val;
   assign exp_rd_addr   = idx_ff;

   // Sequencer: exp pass over the row, then a divide pass per element.
   always_comb begin
      state_in     = state_ff;
      job_in       = job_ff;
      idx_in       = idx_ff;
      y_in         = y_ff;
      sum_in       = sum_ff;
      rem_in       = rem_ff;
      quo_in       = quo_ff;
      step_in      = step_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      job_pop      = 1'b0;
      exp_wr_en    = 1'b0;
      row_done     = 1'b0;
      case (state_ff)
         smr_pkg::BK_IDLE: begin
            if (job_valid) begin
               job_pop  = 1'b1;
               job_in   = job_data;
               idx_in   = '0;
               sum_in   = '0;
               state_in = smr_pkg::BK_EXP_RD;
            end
         end
         smr_pkg::BK_EXP_RD: begin
            state_in = smr_pkg::BK_EXP_MUL;
         end
         smr_pkg::BK_EXP_MUL: begin
            y_in     = prod[24:8];
            state_in = smr_pkg::BK_EXP_ACC;
         end
         smr_pkg::BK_EXP_ACC: begin
            exp_wr_en = 1'b1;
            sum_in    = sum_ff + SUM_W'(exp_val);
            if (idx_last) begin
               idx_in   = '0;
               state_in = smr_pkg::BK_DIV_RD;
            end else begin
               idx_in   = idx_ff + IDX_W'(1);
               state_in = smr_pkg::BK_EXP_RD;
            end
         end
         smr_pkg::BK_DIV_RD: begin
            state_in = smr_pkg::BK_DIV_LOAD;
         end
         smr_pkg::BK_DIV_LOAD: begin
            // The integer bit: e never exceeds the sum, so it is 0 or 1.
            if (exp_ext >= sum_ff) begin
               quo_in = 17'd1;
               rem_in = exp_ext - sum_ff;
            end else begin
               quo_in = 17'd0;
               rem_in = exp_ext;
            end
            step_in  = '0;
            state_in = smr_pkg::BK_DIV_RUN;
         end
         smr_pkg::BK_DIV_RUN: begin
            rem_in  = trial_ge ? SUM_W'(trial - {1'b0, sum_ff}) : SUM_W'(trial);
            quo_in  = {quo_ff[15:0], trial_ge};
            step_in = step_ff + 4'd1;
            if (step_ff == 4'(smr_pkg::FRAC_STEPS - 1)) begin
               state_in = smr_pkg::BK_DIV_OUT;
            end
         end
         smr_pkg::BK_DIV_OUT: begin
            if (out_free) begin
               rsp_valid_in       = 1'b1;
               rsp_in.prob        = quo_ff;
               rsp_in.last_out    = idx_last;
               rsp_in.truncated   = job_ff.overflow;
               if (idx_last) begin
                  row_done = 1'b1;
                  state_in = smr_pkg::BK_IDLE;
               end else begin
                  idx_in   = idx_ff + IDX_W'(1);
                  state_in = smr_pkg::BK_DIV_RD;
               end
            end
         end
         default: begin
            state_in = smr_pkg::BK_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= smr_pkg::BK_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      job_ff  <= job_in;
      idx_ff  <= idx_in;
      y_ff    <= y_in;
      sum_ff  <= sum_in;
      rem_ff  <= rem_in;
      quo_ff  <= quo_in;
      step_ff <= step_in;
      rsp_ff  <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

FILE: rtl/core/softmax_row.sv
// Channel   Ports                            Moves
// -------   ------------------------------   ------------------------------------
// request   req_valid, req_stall, req_data   one score item, Q8.8 plus end flag
// response  rsp_valid, rsp_stall, rsp_data   one probability item, Q1.16 plus flags
//
// Each score that fits is written to its bank as it is accepted; a row then takes an
// exp pass (read, multiply, accumulate) and a divide pass on the bit-serial divider.
// Two score banks let the next row load while the back end still works on the last one.
// Reset is synchronous, active high; it clears FSM and bookkeeping, not memories.
// req_stall is high while both banks hold rows whose last result is not yet issued.
// A stalled response stays in the output register; the divider waits only to emit.
module softmax_row #(
   parameter int MAX_COLS = 64
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  smr_pkg::req_item_type req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output smr_pkg::rsp_item_type rsp_data
);

   localparam int IDX_W = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
   localparam int CNT_W = $clog2(MAX_COLS + 1);
   localparam int SUM_W = $clog2(MAX_COLS) + smr_pkg::EXP_W;
   localparam int JOB_W = 1 + CNT_W + smr_pkg::SCORE_W + 1;

   logic                        score_wr_en;
   logic [IDX_W:0]              score_wr_addr;
   logic [smr_pkg::SCORE_W-1:0] score_wr_data;
   logic [IDX_W:0]              score_rd_addr;
   logic [smr_pkg::SCORE_W-1:0] score_rd_data;
   logic                        exp_wr_en;
   logic [IDX_W-1:0]            exp_wr_addr;
   logic [smr_pkg::EXP_W-1:0]   exp_wr_data;
   logic [IDX_W-1:0]            exp_rd_addr;
   logic [smr_pkg::EXP_W-1:0]   exp_rd_data;
   logic                        job_push;
   logic [JOB_W-1:0]            push_data;
   logic                        job_pop;
   logic                        job_valid;
   logic [JOB_W-1:0]            head_data;
   logic                        row_done;

   // Front end: stores scores and closes rows.
   smr_front #(
      .MAX_COLS (MAX_COLS),
      .IDX_W    (IDX_W),
      .CNT_W    (CNT_W),
      .JOB_W    (JOB_W)
   ) u_front (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_data      (req_data),
      .score_wr_en   (score_wr_en),
      .score_wr_addr (score_wr_addr),
      .score_wr_data (score_wr_data),
      .job_push      (job_push),
      .job_data      (push_data),
      .row_done      (row_done)
   );

   // Closed rows waiting for the back end.
   smr_queue #(
      .DATA_W (JOB_W)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (job_push),
      .push_data  (push_data),
      .pop        (job_pop),
      .head_valid (job_valid),
      .head_data  (head_data)
   );

   // Two banks of scores, selected by the top address bit.
   smr_ram #(
      .WIDTH (smr_pkg::SCORE_W),
      .DEPTH (2 << IDX_W)
   ) u_score_ram (
      .clock   (clock),
      .wr_en   (score_wr_en),
      .wr_addr (score_wr_addr),
      .wr_data (score_wr_data),
      .rd_addr (score_rd_addr),
      .rd_data (score_rd_data)
   );

   // Exponentials of the row under work.
   smr_ram #(
      .WIDTH (smr_pkg::EXP_W),
      .DEPTH (1 << IDX_W)
   ) u_exp_ram (
      .clock   (clock),
      .wr_en   (exp_wr_en),
      .wr_addr (exp_wr_addr),
      .wr_data (exp_wr_data),
      .rd_addr (exp_rd_addr),
      .rd_data (exp_rd_data)
   );

   // Back end: exp pass, divide pass and the output register.
   smr_back #(
      .IDX_W (IDX_W),
      .CNT_W (CNT_W),
      .SUM_W (SUM_W),
      .JOB_W (JOB_W)
   ) u_back (
      .clock         (clock),
      .reset         (reset),
      .job_valid     (job_valid),
      .job_data      (head_data),
      .job_pop       (job_pop),
      .score_rd_addr (score_rd_addr),
      .score_rd_data (score_rd_data),
      .exp_wr_en     (exp_wr_en),
      .exp_wr_addr   (exp_wr_addr),
      .exp_wr_data   (exp_wr_data),
      .exp_rd_addr   (exp_rd_addr),
      .exp_rd_data   (exp_rd_data),
      .row_done      (row_done),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_data      (rsp_data)
   );

endmodule

FILE: test/softmax_row_test.sv
module softmax_row_test;

   localparam int ROW_CAP   = 64;
   localparam int CYCLE_CAP = 1500000;

   logic                  clock;
   logic                  reset;
   logic                  req_valid;
   logic                  req_stall;
   smr_pkg::req_item_type req_data;
   logic                  rsp_valid;
   logic                  rsp_stall;
   smr_pkg::rsp_item_type rsp_data;

   softmax_row #(.MAX_COLS(ROW_CAP)) dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data)
   );

   // Clock with a period of four time units.
   always begin
      clock = 1'b0;
      #2;
      clock = 1'b1;
      #2;
   end

   smr_pkg::req_item_type pending_items[$];
   smr_pkg::rsp_item_type expected_probs[$];
   int                    mismatch_count;
   int                    cycle_count;
   bit                    hold_sender;
   bit                    req_accepted;

   // Predictor state: the exp table, the current row and its running maximum.
   logic [16:0]        pow2_table[256];
   logic signed [15:0] row_scores[ROW_CAP];
   logic signed [15:0] row_peak;
   int                 row_len;
   bit                 row_dropped;

   // Table by rounding the real power of two; every entry sits far enough
   // from a rounding tie that double precision gives the exact value.
   function automatic void fill_pow2_table();
      real v;
      pow2_table[0] = 17'd65536;
      for (int f = 1; f < 256; f++) begin
         v = 65536.0 * $pow(2.0, -real'(f) / 256.0);
         pow2_table[f] = 17'($rtoi(v + 0.5));
      end
   endfunction

   // Fold one accepted item into the row; on the row end predict all results.
   function automatic void predict_softmax(smr_pkg::req_item_type item);
      logic [16:0]           exps[ROW_CAP];
      logic [22:0]           total;
      logic [15:0]           diff;
      logic [31:0]           scaled;
      logic [15:0]           shift;
      smr_pkg::rsp_item_type r;
      if (row_len < ROW_CAP) begin
         row_scores[row_len] = item.score;
         if (item.score > row_peak) row_peak = item.score;
         row_len++;
      end else begin
         row_dropped = 1'b1;
      end
      if (!item.last_in_row) return;
      total = '0;
      for (int k = 0; k < row_len; k++) begin
         diff   = 16'(row_peak - row_scores[k]);
         scaled = (32'(diff) * 32'd369) >> 8;
         shift  = 16'(scaled >> 8);
         exps[k] = (shift >= 16'd17) ? 17'd0 : (pow2_table[scaled[7:0]] >> shift);
         total  += 23'(exps[k]);
      end
      for (int k = 0; k < row_len; k++) begin
         r.prob      = (total == 0) ? 17'd0 : 17'((64'(exps[k]) << 16) / 64'(total));
         r.last_out  = (k == row_len - 1);
         r.truncated = row_dropped;
         expected_probs.push_back(r);
      end
      row_peak    = -16'sd32768;
      row_len     = 0;
      row_dropped = 1'b0;
   endfunction

   task automatic report_mismatch(string what);
      $display("mismatch at cycle %0d: %s", cycle_count, what);
      mismatch_count++;
   endtask

   // Helpers that queue a row of random items or a single item.
   function automatic void queue_row(int len, int lo, int hi);
      smr_pkg::req_item_type it;
      for (int i = 0; i < len; i++) begin
         it.score       = 16'($urandom_range(hi - lo) + lo);
         it.last_in_row = (i == len - 1);
         pending_items.push_back(it);
      end
   endfunction

   function automatic void queue_item(int score, bit last);
      smr_pkg::req_item_type it;
      it.score       = 16'(score);
      it.last_in_row = last;
      pending_items.push_back(it);
   endfunction

   // Driver: bursts of items with random gaps, changing at the falling edge.
   int burst_left;
   int gap_left;
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (req_valid && !req_accepted) begin
         // Hold the stalled item.
      end else begin
         if (req_valid) void'(pending_items.pop_front());
         if (gap_left > 0) begin
            gap_left--;
            req_valid <= 1'b0;
         end else if (pending_items.size() == 0 || hold_sender) begin
            req_valid <= 1'b0;
         end else begin
            req_valid <= 1'b1;
            req_data  <= pending_items[0];
            if (burst_left == 0) begin
               burst_left = $urandom_range(20, 1);
               gap_left   = ($urandom_range(3) == 0) ? 0 : $urandom_range(6);
            end else begin
               burst_left--;
            end
         end
      end
   end

   // Receiver stall pattern: long open stretches mixed with choppy ones.
   int stall_phase;
   always @(negedge clock) begin
      stall_phase++;
      if (reset) rsp_stall <= 1'b0;
      else if ((stall_phase / 200) % 3 == 0) rsp_stall <= 1'b0;
      else rsp_stall <= ($urandom_range(99) < 40);
   end

   // Monitor: accept items and results at the rising edge.
   smr_pkg::rsp_item_type want;
   always @(posedge clock) begin
      req_accepted = req_valid && !req_stall && !reset;
      if (!reset) begin
         cycle_count++;
         if (req_valid && !req_stall) predict_softmax(req_data);
         if (rsp_valid && !rsp_stall) begin
            if (expected_probs.size() == 0) begin
               report_mismatch("result with none expected");
            end else begin
               want = expected_probs.pop_front();
               if (rsp_data.prob !== want.prob)
                  report_mismatch($sformatf("prob %0d, expected %0d",
                                            rsp_data.prob, want.prob));
               if (rsp_data.last_out !== want.last_out)
                  report_mismatch($sformatf("last_out %0b, expected %0b",
                                            rsp_data.last_out, want.last_out));
               if (rsp_data.truncated !== want.truncated)
                  report_mismatch($sformatf("truncated %0b, expected %0b",
                                            rsp_data.truncated, want.truncated));
            end
         end
         if (cycle_count > CYCLE_CAP) begin
            $display("softmax_row_test failed");
            $finish;
         end
      end
   end

   initial begin
      reset          = 1'b1;
      req_valid      = 1'b0;
      req_data       = '0;
      rsp_stall      = 1'b0;
      mismatch_count = 0;
      cycle_count    = 0;
      burst_left     = 0;
      gap_left       = 0;
      stall_phase    = 0;
      hold_sender    = 1'b0;
      req_accepted   = 1'b0;
      row_peak       = -16'sd32768;
      row_len        = 0;
      row_dropped    = 1'b0;
      fill_pow2_table();
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Directed: single-item rows at the extremes, full spread, a mixed row, equal scores, a short random row.
      queue_item(32767, 1);
      queue_item(-32768, 1);
      queue_item(-32768, 0);
      queue_item(32767, 1);
      queue_item(0, 0);
      queue_item(256, 0);
      queue_item(-256, 0);
      queue_item(16'h5555, 0);
      queue_item(-16'sh2aab, 1);
      queue_item(100, 0);
      queue_item(100, 0);
      queue_item(100, 1);
      queue_row(5, -8, 8);

      // Send the directed rows, then pause until every result is back.
      wait (pending_items.size() == 0 && !req_valid);
      hold_sender = 1'b1;
      wait (expected_probs.size() == 0);
      queue_row(ROW_CAP, -32768, 32767);
      // Row past capacity: dropped items, one carrying the row end.
      queue_row(ROW_CAP + 3, -2000, 2000);
      hold_sender = 1'b0;
      wait (pending_items.size() == 0 && expected_probs.size() == 0);

      // Random rows: mostly short with narrow spreads, a few wide or full.
      while (pending_items.size() < 160) begin
         case ($urandom_range(9))
            0:       queue_row($urandom_range(ROW_CAP + 4, ROW_CAP - 2), -32768, 32767);
            1, 2:    queue_row($urandom_range(8, 1), -32768, 32767);
            default: queue_row($urandom_range(8, 1), -1500, 1500);
         endcase
      end

      wait (pending_items.size() == 0 && !req_valid && expected_probs.size() == 0);
      repeat (100) @(posedge clock);
      if (mismatch_count == 0 && expected_probs.size() == 0) begin
         $display("softmax_row_test passed");
      end else begin
         $display("softmax_row_test failed");
      end
      $finish;
   end

endmodule

FILE: sim.f
rtl/core/smr_pkg.sv
rtl/core/smr_ram.sv
rtl/core/smr_queue.sv
rtl/core/smr_front.sv
rtl/core/smr_back.sv
rtl/core/softmax_row.sv
test/softmax_row_test.sv
